FILE: hdl/stt_pkg.sv
// ----------------------------------------------------------------------------
// stt_pkg: shared types and constants of the source text tokenizer
// Token kinds, byte classes, the result word layout and the byte classifier.
// ----------------------------------------------------------------------------
package stt_pkg;

  // Default widths of the internal position and length counters
  localparam int LENGTH_BITS_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;

  // Fixed widths of the reported fields
  localparam int TOKEN_START_W  = 32;
  localparam int TOKEN_LENGTH_W = 16;

  // Byte constants
  localparam logic [7:0] HIGH_LIMIT = 8'h80;

  // Lexer mode: kind of the open token, or none open
  typedef enum logic [2:0] {
    MODE_BLANK   = 3'd0,
    MODE_NEWLINE = 3'd1,
    MODE_OPER    = 3'd2,
    MODE_IDENT   = 3'd3,
    MODE_NUMBER  = 3'd4,
    MODE_NONE    = 3'd5
  } mode_t;

  // Byte class
  typedef enum logic [2:0] {
    CLS_BLANK   = 3'd0,
    CLS_NEWLINE = 3'd1,
    CLS_OPER    = 3'd2,
    CLS_LETTER  = 3'd3,
    CLS_DIGIT   = 3'd4,
    CLS_HIGH    = 3'd5,
    CLS_BAD     = 3'd6
  } cls_t;

  // One result word
  typedef struct packed {
    logic [2:0]                kind;
    logic [TOKEN_START_W-1:0]  start;
    logic [TOKEN_LENGTH_W-1:0] length;
    logic                      err;
    logic                      done;
    logic                      last;
  } tok_res_t;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    case (b) inside
      8'h0A:                                    c = CLS_NEWLINE;
      8'h20, 8'h09:                             c = CLS_BLANK;
      [8'h61:8'h7A], [8'h41:8'h5A], 8'h5F:      c = CLS_LETTER;
      [8'h30:8'h39]:                            c = CLS_DIGIT;
      [8'h81:8'hFF]:                            c = CLS_HIGH;
      8'h3B, 8'h27, 8'h22, 8'h2A, 8'h26, 8'h2B, 8'h2D, 8'h3D, 8'h7B, 8'h7D,
      8'h21, 8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7E, 8'h23, 8'h5C, 8'h2F, 8'h2C,
      8'h7C, 8'h3F, 8'h2E, 8'h3E, 8'h3C, 8'h3A, 8'h25, 8'h5E:
                                                c = CLS_OPER;
      default:                                  c = CLS_BAD;
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// source_text_tokenizer: character-class lexer over a byte stream
// Splits source bytes into blank, newline, operator, identifier and number
// tokens, reporting kind, start offset and saturating length of each.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one source byte per word, in_tlast on the last
//   byte of a text. Result channel (out_*): one token or error per word,
//   out_tlast on the last result caused by an input byte.
//   A byte may cause zero, one or two results. It is classed and folded
//   into the lexer state in the cycle it is accepted; its results are
//   written to a four-word output queue and leave it on out_* in order.
//   One byte is accepted per cycle, sustained, while the receiver
//   keeps up; the queue write of up to two results per byte sets that
//   figure, since in_tready needs room for two words.
//   When the receiver stalls, hold the queue; in_tready drops once more
//   than two words wait, and rises again as they drain.
//   After an error result, drop all bytes up to and including in_tlast.
//   At the end of a text the lexer state returns to reset, so the next text
//   starts at offset zero. Reset (rst_n low, synchronous) empties the
//   queue and closes any open token.
// ----------------------------------------------------------------------------
module source_text_tokenizer #(
  parameter int LENGTH_BITS   = stt_pkg::LENGTH_BITS_DEF,
  parameter int POSITION_BITS = stt_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic        in_tlast,   // end_of_stream
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [31:0] token_start, [47:32] token_length,
                                  // [48] stream_done, [55:49] zero
  output logic [3:0]  out_tuser,  // [2:0] token_kind, [3] error_flag
  output logic        out_tlast   // last_of_run
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Lexer state
  stt_pkg::mode_t           mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [LENGTH_BITS-1:0]   len_r, len_nxt;
  logic                     pend_r, pend_nxt;
  logic                     absorb_r, absorb_nxt;

  // Step intermediates
  stt_pkg::cls_t            cls;
  logic                     eos;
  logic [POSITION_BITS-1:0] hp;
  stt_pkg::mode_t           mode_m;
  logic [POSITION_BITS-1:0] start_m;
  logic [LENGTH_BITS-1:0]   len_m;
  logic                     skip_tail, go_reset;
  stt_pkg::tok_res_t        res_a, res_b;
  logic                     res_a_vld, res_b_vld;
  logic [LENGTH_BITS:0]     grow1, grow2;
  logic [LENGTH_BITS-1:0]   len_inc1, len_inc2;

  // Output queue
  stt_pkg::tok_res_t        q_mem [QDEPTH];
  logic [QPTR_W-1:0]        wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]          cnt_r, cnt_nxt;
  logic                     in_fire, out_fire;
  logic [1:0]               push_n;
  stt_pkg::tok_res_t        w0, w1;
  stt_pkg::tok_res_t        head;

  assign in_tready = (cnt_r <= (QPTR_W+1)'(QDEPTH - 2));
  assign in_fire   = in_tvalid & in_tready;
  assign eos       = in_tlast;

  // Saturating length growth by one and by two
  assign grow1    = {1'b0, len_r} + (LENGTH_BITS+1)'(1);
  assign grow2    = {1'b0, len_r} + (LENGTH_BITS+1)'(2);
  assign len_inc1 = grow1[LENGTH_BITS] ? '1 : grow1[LENGTH_BITS-1:0];
  assign len_inc2 = grow2[LENGTH_BITS] ? '1 : grow2[LENGTH_BITS-1:0];

  // Lexer step for the byte on in_tdata
  always_comb begin
    cls        = stt_pkg::classify(in_tdata);
    hp         = pos_r - POSITION_BITS'(1);
    mode_m     = mode_r;
    start_m    = start_r;
    len_m      = len_r;
    pend_nxt   = pend_r;
    absorb_nxt = absorb_r;
    pos_nxt    = pos_r + POSITION_BITS'(1);
    skip_tail  = 1'b0;
    go_reset   = 1'b0;
    res_a_vld  = 1'b0;
    res_b_vld  = 1'b0;
    // open token report, used when a new token starts
    res_a.kind   = mode_r;
    res_a.start  = stt_pkg::TOKEN_START_W'(start_r);
    res_a.length = stt_pkg::TOKEN_LENGTH_W'(len_r);
    res_a.err    = 1'b0;
    res_a.done   = 1'b0;
    res_a.last   = 1'b0;

    if (absorb_r) begin
      // drop bytes until the end of the text
      skip_tail = 1'b1;
      go_reset  = eos;
    end else if (pend_r) begin
      pend_nxt = 1'b0;
      if (in_tdata <= stt_pkg::HIGH_LIMIT) begin
        // lone high byte: error at the high byte
        res_a_vld    = 1'b1;
        res_a.kind   = stt_pkg::MODE_BLANK;
        res_a.start  = stt_pkg::TOKEN_START_W'(hp);
        res_a.length = '0;
        res_a.err    = 1'b1;
        res_a.done   = eos;
        skip_tail    = 1'b1;
        go_reset     = eos;
        absorb_nxt   = ~eos;
      end else if (mode_r == stt_pkg::MODE_IDENT || mode_r == stt_pkg::MODE_NUMBER) begin
        mode_m = stt_pkg::MODE_IDENT;
        len_m  = len_inc2;
      end else begin
        res_a_vld = (mode_r != stt_pkg::MODE_NONE);
        mode_m    = stt_pkg::MODE_IDENT;
        start_m   = hp;
        len_m     = LENGTH_BITS'(2);
      end
    end else if (cls == stt_pkg::CLS_BAD || (cls == stt_pkg::CLS_HIGH && eos)) begin
      res_a_vld    = 1'b1;
      res_a.kind   = stt_pkg::MODE_BLANK;
      res_a.start  = stt_pkg::TOKEN_START_W'(pos_r);
      res_a.length = '0;
      res_a.err    = 1'b1;
      res_a.done   = eos;
      skip_tail    = 1'b1;
      go_reset     = eos;
      absorb_nxt   = ~eos;
    end else if (cls == stt_pkg::CLS_HIGH) begin
      // wait for the second byte of a high pair
      pend_nxt  = 1'b1;
      skip_tail = 1'b1;
    end else begin
      case (cls)
        stt_pkg::CLS_BLANK, stt_pkg::CLS_NEWLINE: begin
          if (mode_r == stt_pkg::MODE_BLANK || mode_r == stt_pkg::MODE_NEWLINE) begin
            len_m = len_inc1;
          end else begin
            res_a_vld = (mode_r != stt_pkg::MODE_NONE);
            mode_m    = stt_pkg::mode_t'(cls);
            start_m   = pos_r;
            len_m     = LENGTH_BITS'(1);
          end
        end
        stt_pkg::CLS_OPER: begin
          if (mode_r == stt_pkg::MODE_OPER) begin
            len_m = len_inc1;
          end else begin
            res_a_vld = (mode_r != stt_pkg::MODE_NONE);
            mode_m    = stt_pkg::MODE_OPER;
            start_m   = pos_r;
            len_m     = LENGTH_BITS'(1);
          end
        end
        stt_pkg::CLS_LETTER: begin
          if (mode_r == stt_pkg::MODE_IDENT || mode_r == stt_pkg::MODE_NUMBER) begin
            mode_m = stt_pkg::MODE_IDENT;
            len_m  = len_inc1;
          end else begin
            res_a_vld = (mode_r != stt_pkg::MODE_NONE);
            mode_m    = stt_pkg::MODE_IDENT;
            start_m   = pos_r;
            len_m     = LENGTH_BITS'(1);
          end
        end
        default: begin
          // digit
          if (mode_r == stt_pkg::MODE_IDENT || mode_r == stt_pkg::MODE_NUMBER) begin
            len_m = len_inc1;
          end else begin
            res_a_vld = (mode_r != stt_pkg::MODE_NONE);
            mode_m    = stt_pkg::MODE_NUMBER;
            start_m   = pos_r;
            len_m     = LENGTH_BITS'(1);
          end
        end
      endcase
    end

    // final token of the text
    res_b.kind   = mode_m;
    res_b.start  = stt_pkg::TOKEN_START_W'(start_m);
    res_b.length = stt_pkg::TOKEN_LENGTH_W'(len_m);
    res_b.err    = 1'b0;
    res_b.done   = 1'b1;
    res_b.last   = 1'b1;
    if (!skip_tail && eos) begin
      res_b_vld = (mode_m != stt_pkg::MODE_NONE);
      go_reset  = 1'b1;
    end

    mode_nxt  = mode_m;
    start_nxt = start_m;
    len_nxt   = len_m;
    if (go_reset) begin
      mode_nxt   = stt_pkg::MODE_NONE;
      start_nxt  = '0;
      pos_nxt    = '0;
      len_nxt    = '0;
      pend_nxt   = 1'b0;
      absorb_nxt = 1'b0;
    end
  end

  // Pack results into queue words, marking the last of the byte
  always_comb begin
    w0 = res_a_vld ? res_a : res_b;
    w0.last = ~(res_a_vld & res_b_vld);
    w1 = res_b;
    push_n = in_fire ? (2'(res_a_vld) + 2'(res_b_vld)) : 2'd0;
  end

  assign out_fire   = out_tvalid & out_tready;
  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + QPTR_W'(out_fire);
  assign cnt_nxt    = cnt_r + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= stt_pkg::MODE_NONE;
      start_r  <= '0;
      pos_r    <= '0;
      len_r    <= '0;
      pend_r   <= 1'b0;
      absorb_r <= 1'b0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_fire) begin
        mode_r   <= mode_nxt;
        start_r  <= start_nxt;
        pos_r    <= pos_nxt;
        len_r    <= len_nxt;
        pend_r   <= pend_nxt;
        absorb_r <= absorb_nxt;
      end
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage: no reset, words are qualified by the fill count
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      q_mem[wr_ptr_r] <= w0;
    end
    if (push_n == 2'd2) begin
      q_mem[wr_ptr_r + QPTR_W'(1)] <= w1;
    end
  end

  assign head       = q_mem[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {7'd0, head.done, head.length, head.start};
  assign out_tuser  = {head.err, head.kind};
  assign out_tlast  = head.last;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for source_text_tokenizer
// Streams directed and random source texts into the lexer, predicts every
// token and error word in a small scoreboard and checks the result stream
// word by word under random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_BYTES  = 1450;
  localparam int HOLD_CYCLES   = 400;

  // --------------------------------------------------------------------------
  // Token scoreboard: tracks the lexer state, queues the words each accepted
  // byte should produce and checks result words in order.
  // --------------------------------------------------------------------------
  class token_checker;
    string               oper_chars = ";'\"*&+-={}!()[]~#\\/,|?.><:%^";
    stt_pkg::tok_res_t   expected_tokens[$];
    stt_pkg::tok_res_t   fresh[$];
    int                  mismatches;
    stt_pkg::mode_t      open_kind;
    bit [31:0]           run_start;
    bit [31:0]           next_pos;
    bit [15:0]           run_len;
    bit                  high_waiting;
    bit                  skipping;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      open_kind    = stt_pkg::MODE_NONE;
      run_start    = '0;
      next_pos     = '0;
      run_len      = '0;
      high_waiting = 1'b0;
      skipping     = 1'b0;
    endfunction

    function stt_pkg::cls_t class_of(bit [7:0] b);
      if (b == 8'h0A) return stt_pkg::CLS_NEWLINE;
      if (b == " " || b == 8'h09) return stt_pkg::CLS_BLANK;
      if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_")
        return stt_pkg::CLS_LETTER;
      if (b >= "0" && b <= "9") return stt_pkg::CLS_DIGIT;
      if (b > stt_pkg::HIGH_LIMIT) return stt_pkg::CLS_HIGH;
      for (int i = 0; i < oper_chars.len(); i++)
        if (oper_chars[i] == b) return stt_pkg::CLS_OPER;
      return stt_pkg::CLS_BAD;
    endfunction

    // Saturate at the top of the length counter
    function void lengthen();
      if (run_len != 16'hFFFF) run_len++;
    endfunction

    function void stage(logic [2:0] kind, bit [31:0] start, bit [15:0] len, bit err, bit done);
      stt_pkg::tok_res_t w;
      w.kind   = kind;
      w.start  = start;
      w.length = len;
      w.err    = err;
      w.done   = done;
      w.last   = 1'b0;
      fresh.push_back(w);
    endfunction

    function void close_run(bit done);
      if (open_kind != stt_pkg::MODE_NONE) stage(open_kind, run_start, run_len, 1'b0, done);
    endfunction

    function void open_run(stt_pkg::mode_t kind, bit [31:0] start, bit [15:0] len);
      open_kind = kind;
      run_start = start;
      run_len   = len;
    endfunction

    // Error words carry kind zero and length zero; drop the open token
    function void flag_error(bit [31:0] at, bit eos);
      stage(stt_pkg::MODE_BLANK, at, 16'd0, 1'b1, eos);
      if (eos) restart();
      else skipping = 1'b1;
    endfunction

    function void commit();
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) expected_tokens.push_back(fresh[i]);
    endfunction

    // Fold one accepted byte into the state; returns 1 if the lexer skips it
    function bit note_byte(bit [7:0] b, bit eos);
      stt_pkg::cls_t c;
      bit [31:0]     pos;
      fresh.delete();
      pos = next_pos;
      if (skipping) begin
        if (eos) restart();
        return 1'b1;
      end
      if (high_waiting) begin
        high_waiting = 1'b0;
        if (b <= stt_pkg::HIGH_LIMIT) begin
          // lone high byte: report it, swallow the byte that followed
          flag_error(pos - 1, eos);
          commit();
          return 1'b0;
        end
        if (open_kind == stt_pkg::MODE_IDENT || open_kind == stt_pkg::MODE_NUMBER) begin
          open_kind = stt_pkg::MODE_IDENT;
          lengthen();
          lengthen();
        end else begin
          close_run(1'b0);
          open_run(stt_pkg::MODE_IDENT, pos - 1, 16'd2);
        end
      end else begin
        c = class_of(b);
        if (c == stt_pkg::CLS_BAD || (c == stt_pkg::CLS_HIGH && eos)) begin
          flag_error(pos, eos);
          commit();
          return 1'b0;
        end
        if (c == stt_pkg::CLS_HIGH) begin
          high_waiting = 1'b1;
          next_pos     = pos + 1;
          return 1'b0;
        end
        case (c)
          stt_pkg::CLS_BLANK, stt_pkg::CLS_NEWLINE: begin
            if (open_kind == stt_pkg::MODE_BLANK || open_kind == stt_pkg::MODE_NEWLINE)
              lengthen();
            else begin
              close_run(1'b0);
              open_run(c == stt_pkg::CLS_BLANK ? stt_pkg::MODE_BLANK : stt_pkg::MODE_NEWLINE,
                       pos, 16'd1);
            end
          end
          stt_pkg::CLS_OPER: begin
            if (open_kind == stt_pkg::MODE_OPER) lengthen();
            else begin
              close_run(1'b0);
              open_run(stt_pkg::MODE_OPER, pos, 16'd1);
            end
          end
          stt_pkg::CLS_LETTER: begin
            if (open_kind == stt_pkg::MODE_IDENT || open_kind == stt_pkg::MODE_NUMBER) begin
              open_kind = stt_pkg::MODE_IDENT;
              lengthen();
            end else begin
              close_run(1'b0);
              open_run(stt_pkg::MODE_IDENT, pos, 16'd1);
            end
          end
          default: begin
            if (open_kind == stt_pkg::MODE_IDENT || open_kind == stt_pkg::MODE_NUMBER)
              lengthen();
            else begin
              close_run(1'b0);
              open_run(stt_pkg::MODE_NUMBER, pos, 16'd1);
            end
          end
        endcase
      end
      if (eos) begin
        close_run(1'b1);
        restart();
      end else begin
        next_pos = pos + 1;
      end
      commit();
      return 1'b0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_token(stt_pkg::tok_res_t got);
      stt_pkg::tok_res_t want;
      if (expected_tokens.size() == 0) begin
        report($sformatf("unexpected word kind %0d start %0d length %0d err %0b",
                         got.kind, got.start, got.length, got.err));
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d (start %0d)", got.kind, want.kind, want.start));
      if (got.start !== want.start)
        report($sformatf("start %0d, want %0d", got.start, want.start));
      if (got.length !== want.length)
        report($sformatf("length %0d, want %0d (start %0d)", got.length, want.length,
                         want.start));
      if (got.err !== want.err)
        report($sformatf("error flag %0b, want %0b (start %0d)", got.err, want.err, want.start));
      if (got.done !== want.done)
        report($sformatf("stream done %0b, want %0b (start %0d)", got.done, want.done,
                         want.start));
      if (got.last !== want.last)
        report($sformatf("last of run %0b, want %0b (start %0d)", got.last, want.last,
                         want.start));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  always #10 clk = ~clk;

  source_text_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] byte_value
    .in_tlast   (in_tlast),    // end_of_stream
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [31:0] start, [47:32] length, [48] done
    .out_tuser  (out_tuser),   // [2:0] kind, [3] error flag
    .out_tlast  (out_tlast)    // last word of this byte
  );

  token_checker sb = new();

  bit         hold_request = 1'b0;  // ask the receiver for one long hold-off
  bit         idle_on      = 1'b1;  // sender leaves gaps between bursts
  int         burst_left   = 0;
  int         useful_bytes = 0;     // accepted bytes the lexer did not skip
  int         cycle_count  = 0;
  bit [7:0]   text_bytes[$];

  // --------------------------------------------------------------------------
  // Watchdog: end the run as failed if it outlives the cycle budget
  // --------------------------------------------------------------------------
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: a random stall pattern holds for a random span; a requested
  // hold-off keeps tready low long enough for the output queue to fill and
  // back-pressure the input
  // --------------------------------------------------------------------------
  initial begin : receiver
    int pattern;
    int span;
    int phase;
    int hold_left;
    pattern   = 0;
    span      = 0;
    phase     = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (span == 0) begin
        pattern = $urandom_range(0, 3);
        span    = $urandom_range(40, 300);
      end
      span--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (pattern)
          0:       out_tready <= 1'b1;                         // keep up
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= ($urandom_range(0, 3) == 0);  // mostly stalled
          default: out_tready <= ((phase % 5) < 3);            // fixed duty
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: sample at the falling edge, where every signal is settled,
  // the words that the next rising edge will transfer
  // --------------------------------------------------------------------------
  always @(negedge clk) begin : result_monitor
    stt_pkg::tok_res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind   = out_tuser[2:0];
      got.err    = out_tuser[3];
      got.start  = out_tdata[31:0];
      got.length = out_tdata[47:32];
      got.done   = out_tdata[48];
      got.last   = out_tlast;
      sb.check_token(got);
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // Offer one byte; called at a rising edge, returns at the edge that took it
  task send_byte(input bit [7:0] b, input bit eos);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (idle_on) begin
        gap = $urandom_range(1, 6);
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    // hold the word until tready is seen between edges
    do @(negedge clk); while (!in_tready);
    if (!sb.note_byte(b, eos)) useful_bytes++;
    @(posedge clk);
  endtask

  task send_text();
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  // Hold the sender until every expected word has come out
  task wait_for_tokens();
    in_tvalid <= 1'b0;
    while (sb.expected_tokens.size() != 0) @(posedge clk);
  endtask

  function bit [7:0] pick_byte(stt_pkg::cls_t c);
    bit [7:0] b;
    int r;
    case (c)
      stt_pkg::CLS_LETTER: begin
        r = $urandom_range(0, 52);
        b = (r < 26) ? 8'("a" + r) : (r < 52) ? 8'("A" + r - 26) : 8'("_");
      end
      stt_pkg::CLS_DIGIT:   b = 8'("0" + $urandom_range(0, 9));
      stt_pkg::CLS_BLANK:   b = $urandom_range(0, 1) ? 8'h20 : 8'h09;
      stt_pkg::CLS_NEWLINE: b = 8'h0A;
      stt_pkg::CLS_OPER:    b = sb.oper_chars[$urandom_range(0, sb.oper_chars.len() - 1)];
      stt_pkg::CLS_HIGH:    b = 8'($urandom_range(8'h81, 8'hFF));
      default: begin
        do b = 8'($urandom_range(0, 255)); while (sb.class_of(b) != stt_pkg::CLS_BAD);
      end
    endcase
    return b;
  endfunction

  // Build a well-formed text of class runs; optionally break it once
  function void build_text(int runs, bit broken);
    int            w;
    int            p;
    stt_pkg::cls_t c;
    text_bytes.delete();
    repeat (runs) begin
      w = $urandom_range(0, 99);
      if (w < 28)      c = stt_pkg::CLS_LETTER;
      else if (w < 48) c = stt_pkg::CLS_DIGIT;
      else if (w < 62) c = stt_pkg::CLS_BLANK;
      else if (w < 70) c = stt_pkg::CLS_NEWLINE;
      else if (w < 88) c = stt_pkg::CLS_OPER;
      else             c = stt_pkg::CLS_HIGH;
      repeat ($urandom_range(1, 6)) begin
        // high bytes go in pairs so they form letters
        if (c == stt_pkg::CLS_HIGH) text_bytes.push_back(pick_byte(stt_pkg::CLS_HIGH));
        text_bytes.push_back(pick_byte(c));
      end
    end
    if (broken) begin
      p = $urandom_range(0, text_bytes.size());
      case ($urandom_range(0, 2))
        0: text_bytes.insert(p, pick_byte(stt_pkg::CLS_BAD));
        1: begin
          text_bytes.insert(p, 8'($urandom_range(0, 8'h80)));
          text_bytes.insert(p, pick_byte(stt_pkg::CLS_HIGH));
        end
        default: text_bytes.push_back(pick_byte(stt_pkg::CLS_HIGH));  // high byte ends the text
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    bit hold_done;
    bit pause_done;
    int w;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed texts
    // number turned identifier, whitespace merge, operator merge, high pair
    // after an operator continued by a digit, final token closed by the end
    text_bytes = '{"9", "a", " ", "\n", "+", "=", 8'hC3, 8'hA9, "7", ";"};
    send_text();
    // lone high byte, then skip bytes up to the end of the text
    text_bytes = '{8'hFF, "a", "x", "y"};
    send_text();
    // unacceptable byte that also ends the text
    text_bytes = '{8'h00};
    send_text();
    // 0x80 is not a high byte; the next byte is skipped
    text_bytes = '{8'h80, 8'h81};
    send_text();
    // high byte on the last position drops the open identifier
    text_bytes = '{"a", 8'hFE};
    send_text();
    // one-byte text
    text_bytes = '{"5"};
    send_text();
    // lone high byte followed by the end of the text
    text_bytes = '{8'hC0, 8'h20};
    send_text();
    // tab, underscore and upper-case letter
    text_bytes = '{8'h09, "_", "Z"};
    send_text();
    wait_for_tokens();

    // Random texts
    useful_bytes = 0;
    while (useful_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) idle_on = ($urandom_range(0, 3) != 0);
      w = $urandom_range(0, 99);
      if (w < 5) begin
        // noise: raw bytes of any value
        text_bytes.delete();
        repeat ($urandom_range(1, 20)) text_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_text($urandom_range(1, 12), w < 20);
      end
      send_text();
      if (!hold_done && useful_bytes > 500) begin
        hold_done    = 1'b1;
        hold_request = 1'b1;
      end
      if (!pause_done && useful_bytes > 1000) begin
        pause_done = 1'b1;
        wait_for_tokens();
      end
    end

    // Drain and let the output queue settle
    in_tvalid <= 1'b0;
    wait_for_tokens();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
